// File: rtl/mha_pkg.sv
package mha_pkg;

	localparam logic [1:0] OP_READING = 2'd0;
	localparam logic [1:0] OP_ACK_ALL = 2'd1;
	localparam logic [1:0] OP_LOAD    = 2'd2;

	localparam logic [1:0] SEL_HIGH = 2'd0;
	localparam logic [1:0] SEL_LOW  = 2'd1;
	localparam logic [1:0] SEL_HYST = 2'd2;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_HIGH  = 2'd1;
	localparam logic [1:0] ST_LOW   = 2'd2;

	localparam logic [1:0] EV_NONE         = 2'd0;
	localparam logic [1:0] EV_RAISED_HIGH  = 2'd1;
	localparam logic [1:0] EV_RAISED_LOW   = 2'd2;
	localparam logic [1:0] EV_CLEARED      = 2'd3;

	typedef struct packed {
		logic signed [15:0] high;
		logic signed [15:0] low;
		logic signed [15:0] hyst;
	} limits_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         channel;
		logic signed [15:0] sample_value;
		logic               sample_valid;
		logic [1:0]         limit_select;
	} item_t;

	typedef struct packed {
		logic [3:0] event_channel;
		logic [1:0] alarm_event;
		logic [1:0] channel_state;
	} result_t;

	// Write-back request from the update logic to both memories.
	typedef struct packed {
		logic       wr_en;
		logic       clr_all;
		logic [1:0] alarm;
		limits_t    limits;
	} update_t;

	// Limits that a channel holds until its first table write.
	function automatic limits_t default_limits(logic [7:0] idx);
		limits_t l;
		l = '0;
		unique case (idx)
			8'd0: begin
				l.high = 16'sd3500;
				l.low  = 16'sd0;
				l.hyst = 16'sd200;
			end
			8'd1: begin
				l.high = 16'sd8000;
				l.low  = 16'sd2000;
				l.hyst = 16'sd500;
			end
			8'd2: begin
				l.high = 16'sd10500;
				l.low  = 16'sd9500;
				l.hyst = 16'sd50;
			end
			default: l = '0;
		endcase
		return l;
	endfunction

endpackage

// File: rtl/mha_req_if.sv
interface mha_req_if;
	import mha_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [3:0]         channel;
	logic signed [15:0] sample_value;
	logic               sample_valid;
	logic [1:0]         limit_select;

	modport source (
		output valid, op, channel, sample_value, sample_valid, limit_select,
		input  ready
	);
	modport sink (
		input  valid, op, channel, sample_value, sample_valid, limit_select,
		output ready
	);
endinterface

// File: rtl/mha_rsp_if.sv
interface mha_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_channel;
	logic [1:0] alarm_event;
	logic [1:0] channel_state;

	modport source (
		output valid, event_channel, alarm_event, channel_state,
		input  ready
	);
	modport sink (
		input  valid, event_channel, alarm_event, channel_state,
		output ready
	);
endinterface

// File: rtl/multichannel_hysteresis_alarm.sv
// Per-channel three-state alarm (clear, high, low) with a high limit, a low
// limit and a hysteresis width for each of CHANNELS channels. Every word taken
// on req gives one word on rsp; it passes the stage-one register and then the
// result register before it can be taken on rsp. The alarm state and the
// limits sit in two memories with a registered read, read as the word is
// taken and written back as it leaves stage one, and the last write is
// forwarded so that a word for the same channel can follow in the next cycle.
// The block sustains one word per cycle while rsp keeps up. Acknowledge-all
// clears every alarm at once, and the limits come out of reset with their
// default values; no clearing pass is needed after reset.
module multichannel_hysteresis_alarm import mha_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input logic       clk,
	input logic       arst_n,
	mha_req_if.sink   req,
	mha_rsp_if.source rsp
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic             accept;
	logic             adv_s1;
	logic [IDX_W-1:0] idx_in;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	item_t            item_s1;
	logic             in_range_s1;

	logic [1:0]       alarm_rd;
	limits_t          limits_rd;
	logic [1:0]       cur_alarm;
	limits_t          cur_limits;

	logic             fwd_vld_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [1:0]       fwd_alarm_q;
	limits_t          fwd_limits_q;
	logic             fwd_hit;

	update_t          upd;
	update_t          upd_gated;
	result_t          res;
	logic             rsp_vld_q;
	result_t          rsp_q;

	assign adv_s1    = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv_s1;
	assign accept    = req.valid && req.ready;
	assign idx_in    = IDX_W'(req.channel);
	assign idx_s1    = IDX_W'(item_s1.channel);
	assign in_range_s1 = {5'd0, item_s1.channel} < 9'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op           <= req.op;
			item_s1.channel      <= req.channel;
			item_s1.sample_value <= req.sample_value;
			item_s1.sample_valid <= req.sample_valid;
			item_s1.limit_select <= req.limit_select;
		end
	end

	assign upd_gated.wr_en   = upd.wr_en && adv_s1;
	assign upd_gated.clr_all = upd.clr_all && adv_s1;
	assign upd_gated.alarm   = upd.alarm;
	assign upd_gated.limits  = upd.limits;

	mha_alarm_mem #(.CHANNELS(CHANNELS)) u_alarm_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (idx_in),
		.rd_data (alarm_rd),
		.wr_idx  (idx_s1),
		.upd     (upd_gated)
	);

	mha_limit_mem #(.CHANNELS(CHANNELS)) u_limit_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (idx_in),
		.rd_data (limits_rd),
		.wr_idx  (idx_s1),
		.upd     (upd_gated)
	);

	// The memory read for a word happens at the same edge as the previous
	// word's write, so it can miss that write. The forwarding register holds
	// the latest write and is dropped on acknowledge-all, after which the
	// memories and valid bits are already current.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (upd_gated.clr_all) begin
			fwd_vld_q <= 1'b0;
		end else if (upd_gated.wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_gated.wr_en) begin
			fwd_idx_q    <= idx_s1;
			fwd_alarm_q  <= upd.alarm;
			fwd_limits_q <= upd.limits;
		end
	end

	assign fwd_hit    = fwd_vld_q && (fwd_idx_q == idx_s1);
	assign cur_alarm  = fwd_hit ? fwd_alarm_q : alarm_rd;
	assign cur_limits = fwd_hit ? fwd_limits_q : limits_rd;

	mha_update u_update (
		.item       (item_s1),
		.in_range   (in_range_s1),
		.cur_alarm  (cur_alarm),
		.cur_limits (cur_limits),
		.upd        (upd),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (!rsp_vld_q || rsp.ready) begin
			rsp_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.event_channel = rsp_q.event_channel;
	assign rsp.alarm_event   = rsp_q.alarm_event;
	assign rsp.channel_state = rsp_q.channel_state;

	a_ack_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.op == OP_ACK_ALL
		|=> rsp.alarm_event == EV_NONE && rsp.channel_state == ST_CLEAR)
		else $error("acknowledge-all produced a non-clear result");

	a_raise_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.alarm_event == EV_RAISED_HIGH |-> rsp.channel_state == ST_HIGH)
		else $error("high alarm raised without high state");

	a_clear_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.alarm_event == EV_CLEARED |-> rsp.channel_state == ST_CLEAR)
		else $error("alarm cleared but state is not clear");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && rsp.valid && !rsp.ready |=> vld_s1 && $stable(item_s1))
		else $error("pending word left stage one while the result was stalled");

endmodule

// File: rtl/mha_alarm_mem.sv
module mha_alarm_mem import mha_pkg::*; #(
	parameter int CHANNELS = 16,
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [1:0]       rd_data,
	input  logic [IDX_W-1:0] wr_idx,
	input  update_t          upd
);

	logic [1:0]          mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [1:0]          rd_data_q;
	logic [IDX_W-1:0]    rd_idx_q;

	always_ff @(posedge clk) begin
		if (upd.wr_en) begin
			mem[wr_idx] <= upd.alarm;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	// Acknowledge-all drops every valid bit, so each entry reads as clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (upd.clr_all) begin
			vld_q <= '0;
		end else if (upd.wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	assign rd_data = vld_q[rd_idx_q] ? rd_data_q : ST_CLEAR;

endmodule

// File: rtl/mha_limit_mem.sv
module mha_limit_mem import mha_pkg::*; #(
	parameter int CHANNELS = 16,
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output limits_t          rd_data,
	input  logic [IDX_W-1:0] wr_idx,
	input  update_t          upd
);

	limits_t             mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	limits_t             rd_data_q;
	logic [IDX_W-1:0]    rd_idx_q;

	always_ff @(posedge clk) begin
		if (upd.wr_en) begin
			mem[wr_idx] <= upd.limits;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (upd.wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// An entry never written still holds its power-up limits.
	assign rd_data = vld_q[rd_idx_q] ? rd_data_q : default_limits(8'(rd_idx_q));

endmodule

// File: rtl/mha_update.sv
module mha_update import mha_pkg::*; (
	input  item_t   item,
	input  logic    in_range,
	input  logic [1:0] cur_alarm,
	input  limits_t cur_limits,
	output update_t upd,
	output result_t res
);

	logic signed [16:0] val;
	logic signed [16:0] hi;
	logic signed [16:0] lo;
	logic signed [16:0] hi_clr;
	logic signed [16:0] lo_clr;
	logic [1:0]         nxt;
	logic [1:0]         ev;
	limits_t            nxt_limits;

	assign val    = 17'(item.sample_value);
	assign hi     = 17'(cur_limits.high);
	assign lo     = 17'(cur_limits.low);
	assign hi_clr = hi - 17'(cur_limits.hyst);
	assign lo_clr = lo + 17'(cur_limits.hyst);

	// A reading between the limits, or one that does not cross its clearing
	// threshold, leaves the state as it is, so no branch is required to match.
	always_comb begin
		nxt        = cur_alarm;
		ev         = EV_NONE;
		nxt_limits = cur_limits;
		if (item.op == OP_READING && item.sample_valid) begin
			if (cur_alarm == ST_CLEAR) begin
				if (val > hi) begin
					nxt = ST_HIGH;
					ev  = EV_RAISED_HIGH;
				end else if (val < lo) begin
					nxt = ST_LOW;
					ev  = EV_RAISED_LOW;
				end
			end else if (cur_alarm == ST_HIGH) begin
				if (val < hi_clr) begin
					nxt = ST_CLEAR;
					ev  = EV_CLEARED;
				end
			end else if (cur_alarm == ST_LOW) begin
				if (val > lo_clr) begin
					nxt = ST_CLEAR;
					ev  = EV_CLEARED;
				end
			end
		end else if (item.op == OP_LOAD) begin
			unique case (item.limit_select)
				SEL_HIGH: nxt_limits.high = item.sample_value;
				SEL_LOW:  nxt_limits.low  = item.sample_value;
				SEL_HYST: nxt_limits.hyst = item.sample_value;
				default:  nxt_limits = cur_limits;
			endcase
		end
	end

	// Every in-range item other than acknowledge-all writes its entry back,
	// changed or not, which keeps the forwarding path uniform.
	always_comb begin
		upd.clr_all       = (item.op == OP_ACK_ALL);
		upd.wr_en         = in_range && !upd.clr_all;
		upd.alarm         = nxt;
		upd.limits        = nxt_limits;
		res.event_channel = item.channel;
		if (upd.wr_en) begin
			res.alarm_event   = ev;
			res.channel_state = nxt;
		end else begin
			res.alarm_event   = EV_NONE;
			res.channel_state = ST_CLEAR;
		end
	end

endmodule

// File: verif/multichannel_hysteresis_alarm_tb.sv
module multichannel_hysteresis_alarm_tb;
	import mha_pkg::*;

	localparam int CHANNELS     = 16;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_WORDS = 500;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;

	// Codes that the block must ignore.
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] SEL_UNUSED = 2'd3;

	typedef struct {
		item_t   word;
		bit      known;
		result_t result;
	} directed_row_t;

	logic clk;
	logic arst_n;

	mha_req_if req_bus ();
	mha_rsp_if rsp_bus ();

	multichannel_hysteresis_alarm #(.CHANNELS(CHANNELS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	logic [1:0] model_alarm [CHANNELS];
	int         high_limit  [CHANNELS];
	int         low_limit   [CHANNELS];
	int         hyst_width  [CHANNELS];

	result_t       expected_results [$];
	directed_row_t directed_rows [$];
	int            mismatches = 0;
	int            cycles = 0;
	bit            sender_steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic clear_alarm_tables();
		foreach (model_alarm[i]) begin
			model_alarm[i] = ST_CLEAR;
			high_limit[i]  = 0;
			low_limit[i]   = 0;
			hyst_width[i]  = 0;
		end
		high_limit[0] = 3500;
		low_limit[0]  = 0;
		hyst_width[0] = 200;
		high_limit[1] = 8000;
		low_limit[1]  = 2000;
		hyst_width[1] = 500;
		high_limit[2] = 10500;
		low_limit[2]  = 9500;
		hyst_width[2] = 50;
	endtask

	// Thresholds are formed in 32-bit ints, so high - hyst and low + hyst
	// cannot wrap.
	function automatic result_t predict_alarm(item_t word);
		result_t    r;
		logic [1:0] cur;
		int         v;
		int         ch;
		r.event_channel = word.channel;
		r.alarm_event   = EV_NONE;
		r.channel_state = ST_CLEAR;
		ch = int'(word.channel);
		v  = int'($signed(word.sample_value));
		if (word.op == OP_ACK_ALL) begin
			foreach (model_alarm[i])
				model_alarm[i] = ST_CLEAR;
		end else if (ch < CHANNELS) begin
			cur = model_alarm[ch];
			r.channel_state = cur;
			if (word.op == OP_READING && word.sample_valid) begin
				case (cur)
					ST_CLEAR: begin
						if (v > high_limit[ch]) begin
							r.channel_state = ST_HIGH;
							r.alarm_event   = EV_RAISED_HIGH;
						end else if (v < low_limit[ch]) begin
							r.channel_state = ST_LOW;
							r.alarm_event   = EV_RAISED_LOW;
						end
					end
					ST_HIGH: begin
						if (v < high_limit[ch] - hyst_width[ch]) begin
							r.channel_state = ST_CLEAR;
							r.alarm_event   = EV_CLEARED;
						end
					end
					ST_LOW: begin
						if (v > low_limit[ch] + hyst_width[ch]) begin
							r.channel_state = ST_CLEAR;
							r.alarm_event   = EV_CLEARED;
						end
					end
					default: ;
				endcase
				model_alarm[ch] = r.channel_state;
			end else if (word.op == OP_LOAD) begin
				case (word.limit_select)
					SEL_HIGH: high_limit[ch] = v;
					SEL_LOW:  low_limit[ch]  = v;
					SEL_HYST: hyst_width[ch] = v;
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	// Readings mostly land a few counts around the current thresholds of the
	// channel so that alarms are raised and cleared often.
	function automatic item_t random_item();
		item_t word;
		int    pick;
		int    ch;
		int    v;
		bit    full;
		word.channel      = 4'($urandom_range(0, 15));
		word.sample_valid = ($urandom_range(0, 9) != 0);
		word.limit_select = 2'($urandom_range(0, 2));
		ch   = int'(word.channel);
		full = ($urandom_range(0, 4) == 0);
		v    = int'($urandom_range(0, 65535)) - 32768;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			word.op = OP_READING;
		else if (pick < 88)
			word.op = OP_LOAD;
		else if (pick < 94)
			word.op = OP_ACK_ALL;
		else if (pick < 97)
			word.op = OP_UNUSED;
		else begin
			word.op = OP_LOAD;
			word.limit_select = SEL_UNUSED;
		end
		if (word.op == OP_READING) begin
			case ($urandom_range(0, 5))
				0: v = high_limit[ch];
				1: v = low_limit[ch];
				2: v = high_limit[ch] - hyst_width[ch];
				3: v = low_limit[ch] + hyst_width[ch];
				default: ;
			endcase
			v = v + int'($urandom_range(0, 6)) - 3;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
		end else if (word.op == OP_LOAD && !full) begin
			if (word.limit_select == SEL_HYST)
				v = int'($urandom_range(0, 800));
			else
				v = int'($urandom_range(0, 14000)) - 2000;
		end
		word.sample_value = 16'(v);
		return word;
	endfunction

	task automatic add_row(logic [1:0] op, int ch, int value, bit vld, logic [1:0] sel,
		bit known, logic [1:0] ev, logic [1:0] st);
		directed_row_t row;
		row.word.op                = op;
		row.word.channel           = ch[3:0];
		row.word.sample_value      = 16'(value);
		row.word.sample_valid      = vld;
		row.word.limit_select      = sel;
		row.known                  = known;
		row.result.event_channel   = ch[3:0];
		row.result.alarm_event     = ev;
		row.result.channel_state   = st;
		directed_rows.push_back(row);
	endtask

	task automatic send_word(item_t word, bit known, result_t typed);
		int      gap;
		result_t predicted;
		if ($urandom_range(0, 29) == 0)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.op           <= word.op;
		req_bus.channel      <= word.channel;
		req_bus.sample_value <= word.sample_value;
		req_bus.sample_valid <= word.sample_valid;
		req_bus.limit_select <= word.limit_select;
		do @(posedge clk); while (!req_bus.ready);
		predicted = predict_alarm(word);
		expected_results.push_back(known ? typed : predicted);
	endtask

	function automatic void report_mismatch(string what, result_t want, result_t got);
		if (mismatches < REPORT_LIMIT)
			$display("%0t %s: expected ch %0d event %0d state %0d, got ch %0d event %0d state %0d",
				$time, what, want.event_channel, want.alarm_event, want.channel_state,
				got.event_channel, got.alarm_event, got.channel_state);
		mismatches++;
	endfunction

	initial begin : stimulus
		arst_n               <= 1'b0;
		req_bus.valid        <= 1'b0;
		req_bus.op           <= OP_READING;
		req_bus.channel      <= '0;
		req_bus.sample_value <= '0;
		req_bus.sample_valid <= 1'b0;
		req_bus.limit_select <= SEL_HIGH;
		sender_steady = 1'b0;
		clear_alarm_tables();

		// Reset limits, threshold edges and both clearing thresholds.
		add_row(OP_READING, 0, 3500, 1, SEL_HIGH, 1, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 0, 3501, 1, SEL_HIGH, 1, EV_RAISED_HIGH, ST_HIGH);
		add_row(OP_READING, 0, 3300, 1, SEL_LOW, 1, EV_NONE, ST_HIGH);
		add_row(OP_READING, 0, 3299, 1, SEL_HIGH, 1, EV_CLEARED, ST_CLEAR);
		add_row(OP_READING, 1, 1999, 1, SEL_HYST, 1, EV_RAISED_LOW, ST_LOW);
		add_row(OP_READING, 1, 2501, 0, SEL_HIGH, 1, EV_NONE, ST_LOW);
		add_row(OP_READING, 1, 2500, 1, SEL_HIGH, 1, EV_NONE, ST_LOW);
		add_row(OP_READING, 1, 2501, 1, SEL_HIGH, 1, EV_CLEARED, ST_CLEAR);
		// Value extremes against zero limits, then acknowledge-all.
		add_row(OP_READING, 3, 32767, 1, SEL_HIGH, 1, EV_RAISED_HIGH, ST_HIGH);
		add_row(OP_READING, 4, -32768, 1, SEL_HIGH, 1, EV_RAISED_LOW, ST_LOW);
		add_row(OP_ACK_ALL, 15, 0, 1, SEL_UNUSED, 1, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 3, 0, 1, SEL_HIGH, 1, EV_NONE, ST_CLEAR);
		// Extreme table words: the thresholds need the extra bit here.
		add_row(OP_LOAD, 5, -32768, 0, SEL_HIGH, 1, EV_NONE, ST_CLEAR);
		add_row(OP_LOAD, 5, 32767, 1, SEL_HYST, 1, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 5, -32767, 1, SEL_HIGH, 1, EV_RAISED_HIGH, ST_HIGH);
		add_row(OP_READING, 5, -32768, 1, SEL_HIGH, 1, EV_NONE, ST_HIGH);
		add_row(OP_LOAD, 6, 32767, 1, SEL_HIGH, 1, EV_NONE, ST_CLEAR);
		add_row(OP_LOAD, 6, 32767, 0, SEL_LOW, 1, EV_NONE, ST_CLEAR);
		add_row(OP_LOAD, 6, 32767, 1, SEL_HYST, 1, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 6, 32766, 1, SEL_HIGH, 1, EV_RAISED_LOW, ST_LOW);
		add_row(OP_READING, 6, 32767, 1, SEL_HIGH, 1, EV_NONE, ST_LOW);
		// Ignored select and ignored op leave the channel as it is.
		add_row(OP_LOAD, 6, -21846, 1, SEL_UNUSED, 1, EV_NONE, ST_LOW);
		add_row(OP_UNUSED, 6, 21845, 1, SEL_UNUSED, 1, EV_NONE, ST_LOW);
		// A negative hysteresis word moves the clearing threshold outward.
		add_row(OP_LOAD, 7, -100, 1, SEL_HYST, 0, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 7, 1, 1, SEL_HIGH, 0, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 7, 50, 1, SEL_HIGH, 0, EV_NONE, ST_CLEAR);
		add_row(OP_READING, 2, 9499, 1, SEL_HIGH, 0, EV_NONE, ST_CLEAR);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2 || $urandom_range(0, 99) == 0) begin
				// Let the block run dry before the next word.
				req_bus.valid <= 1'b0;
				@(posedge clk);
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			send_word(random_item(), 1'b0, '0);
		end
		req_bus.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		int      stall;
		bit      steady;
		result_t got;
		result_t want;
		rsp_bus.ready <= 1'b0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 24) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			got.event_channel = rsp_bus.event_channel;
			got.alarm_event   = rsp_bus.alarm_event;
			got.channel_state = rsp_bus.channel_state;
			if (expected_results.size() == 0) begin
				report_mismatch("word with nothing expected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want)
					report_mismatch("mismatch", want, got);
			end
		end
	end

endmodule

// File: filelist.f
rtl/mha_pkg.sv
rtl/mha_req_if.sv
rtl/mha_rsp_if.sv
rtl/mha_alarm_mem.sv
rtl/mha_limit_mem.sv
rtl/mha_update.sv
rtl/multichannel_hysteresis_alarm.sv
verif/multichannel_hysteresis_alarm_tb.sv
